/* design/divu64_pkg.sv */
package divu64_pkg;

  // Default operand width and the fixed width of the operand/result ports.
  localparam int unsigned DefaultWidth = 64;
  localparam int unsigned PortWidth    = 64;

endpackage

/* design/divu64_stage.sv */
module divu64_stage #(
  parameter int unsigned WIDTH = divu64_pkg::DefaultWidth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [WIDTH-1:0] rem_i,
  input  logic [WIDTH-1:0] num_i,
  input  logic [WIDTH-1:0] quo_i,
  input  logic [WIDTH-1:0] den_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rem_o,
  output logic [WIDTH-1:0] num_o,
  output logic [WIDTH-1:0] quo_o,
  output logic [WIDTH-1:0] den_o
);

  logic             valid_q;
  logic [WIDTH-1:0] rem_q, rem_d;
  logic [WIDTH-1:0] num_q, num_d;
  logic [WIDTH-1:0] quo_q, quo_d;
  logic [WIDTH-1:0] den_q;

  logic [WIDTH-1:0] rem_sh;
  logic [WIDTH:0]   diff;
  logic             fits;

  // Shift in the next dividend bit; remainder stays below 2^WIDTH by construction.
  assign rem_sh = {rem_i[WIDTH-2:0], num_i[WIDTH-1]};
  assign diff   = {1'b0, rem_sh} - {1'b0, den_i};
  assign fits   = ~diff[WIDTH];

  always_comb begin
    rem_d = fits ? diff[WIDTH-1:0] : rem_sh;
    num_d = {num_i[WIDTH-2:0], 1'b0};
    quo_d = {quo_i[WIDTH-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      rem_q <= rem_d;
      num_q <= num_d;
      quo_q <= quo_d;
      den_q <= den_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign num_o   = num_q;
  assign quo_o   = quo_q;
  assign den_o   = den_q;

endmodule

/* design/unsigned_divide_64_top.sv */
// Unsigned restoring divider, one quotient bit per pipeline stage.
//
// Command channel: a word (dividend_i, divisor_i) is taken at a rising edge
// with start_i high and busy_o low. busy_o is always low: the pipeline never
// stalls, so a new word may be issued every cycle.
// Result channel: quotient_o is shown for exactly one cycle with done_o high,
// once the word has passed all WIDTH stages. Results leave in issue order.
// Throughput: one division per cycle. The pipe is a chain of WIDTH
// shift/compare/subtract stages, one WIDTH-bit subtract per stage.
// Only the low WIDTH bits of each operand are used; quotient bits at and
// above WIDTH read as zero. A zero divisor gives an all-ones quotient in
// WIDTH bits.
// Reset clears every stage valid bit at once; words in flight are dropped
// and no done_o strobe appears until new words are issued. The receiver
// cannot hold results off, so nothing is buffered at the output.
module unsigned_divide_64_top #(
  parameter int unsigned WIDTH = divu64_pkg::DefaultWidth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [divu64_pkg::PortWidth-1:0]  dividend_i,
  input  logic [divu64_pkg::PortWidth-1:0]  divisor_i,
  output logic                              done_o,
  output logic [divu64_pkg::PortWidth-1:0]  quotient_o
);

  localparam int unsigned PadWidth = divu64_pkg::PortWidth - WIDTH;

  // Stage k links: index 0 is the command word, index WIDTH the last stage.
  logic             valid_s [WIDTH+1];
  logic [WIDTH-1:0] rem_s   [WIDTH+1];
  logic [WIDTH-1:0] num_s   [WIDTH+1];
  logic [WIDTH-1:0] quo_s   [WIDTH+1];
  logic [WIDTH-1:0] den_s   [WIDTH+1];

  // No back-pressure anywhere in the pipe.
  assign busy_o = 1'b0;

  assign valid_s[0] = start_i & ~busy_o;
  assign rem_s[0]   = '0;
  assign num_s[0]   = dividend_i[WIDTH-1:0];
  assign quo_s[0]   = '0;
  assign den_s[0]   = divisor_i[WIDTH-1:0];

  for (genvar k = 0; k < WIDTH; k++) begin : g_stage
    divu64_stage #(
      .WIDTH(WIDTH)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(valid_s[k]),
      .rem_i  (rem_s[k]),
      .num_i  (num_s[k]),
      .quo_i  (quo_s[k]),
      .den_i  (den_s[k]),
      .valid_o(valid_s[k+1]),
      .rem_o  (rem_s[k+1]),
      .num_o  (num_s[k+1]),
      .quo_o  (quo_s[k+1]),
      .den_o  (den_s[k+1])
    );
  end

  assign done_o = valid_s[WIDTH];

  // Zero-extend to the port width; the pad is empty at full width.
  if (PadWidth > 0) begin : g_pad
    assign quotient_o = {{PadWidth{1'b0}}, quo_s[WIDTH]};
  end else begin : g_nopad
    assign quotient_o = quo_s[WIDTH];
  end

  // Every accepted word strobes out on done_o once it has passed all WIDTH stages.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##WIDTH done_o)
    else $error("accepted word did not complete after WIDTH cycles");

  // A zero divisor yields all ones in the low WIDTH bits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && divisor_i[WIDTH-1:0] == '0)
      |-> ##WIDTH (quotient_o[WIDTH-1:0] == {WIDTH{1'b1}}))
    else $error("zero divisor did not give all-ones quotient");

  // Dividing by one returns the masked dividend.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && divisor_i[WIDTH-1:0] == WIDTH'(1))
      |-> ##WIDTH (quotient_o[WIDTH-1:0] == $past(dividend_i[WIDTH-1:0], WIDTH)))
    else $error("divide by one did not return the dividend");

endmodule
